// ===== rtl/tcq_pkg.sv =====
// Shared types, constants and helpers for the timecode quarter-frame counter.
// No dependencies; included by every rtl module through a wildcard import.
package tcq_pkg;

	// Serial divider widths: 37-bit dividend, divisor and remainder below 2^20
	localparam int DVD_W  = 37;
	localparam int REM_W  = 20;
	localparam int CNT_W  = 6;
	localparam int FPS_W  = 5;
	localparam int TIME_W = 37;

	// Frame rate mode codes; every other code selects 30 fps
	localparam logic [1:0] MODE_24FPS = 2'd0;
	localparam logic [1:0] MODE_25FPS = 2'd1;

	// Request to the bit-serial divider; dividend is left-aligned to nbits
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DVD_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} div_req_t;

	// Divider response; quot and rem are valid while done is high
	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

	// Update strobes for the timecode field registers
	typedef struct packed {
		logic tick;
		logic set_sec;
		logic set_hm;
		logic set_frm;
	} fld_ctl_t;

	// Frames per second for a mode code
	function automatic logic [FPS_W-1:0] fps_of(input logic [1:0] mode);
		logic [FPS_W-1:0] fps;
		case (mode)
			MODE_24FPS: fps = 5'd24;
			MODE_25FPS: fps = 5'd25;
			default:    fps = 5'd30;
		endcase
		return fps;
	endfunction

endpackage

// ===== rtl/timecode_quarter_frame_counter.sv =====
// Top level of the timecode quarter-frame counter: handshake, sequencer,
// load and readout datapath. Depends on tcq_pkg, tcq_div and tcq_fields.
//
// Holds hours:minutes:seconds:frames.subframes at 24, 25 or 30 fps (mode
// register, codes 2 and 3 both 30). Each input transfer either advances the
// code by a quarter frame or loads it from a microsecond time (clamped to one
// day, truncated), and yields one result with the fields and the time in
// microseconds, fractional frame truncated. All divisions go through one
// restoring divider that retires a quotient bit per clock. A load
// runs divides of 37, 17, 11, 25 and 12 bits and then the 25-bit
// readout divide by the frame rate, while a tick runs only the
// readout divide. One item is in work at a time;
// the next is taken once the result is in the output register, which holds
// it until the receiver transfers it. Write the mode only while idle.
module timecode_quarter_frame_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [36:0] load_time_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	output logic [4:0]  frames,
	output logic [6:0]  subframes,
	output logic [36:0] time_us
);
	import tcq_pkg::*;

	localparam logic REQ_LOAD = 1'b1;

	// Sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_LD_SEC   = 4'd1;
	localparam logic [3:0] S_LD_MIN   = 4'd2;
	localparam logic [3:0] S_LD_HR    = 4'd3;
	localparam logic [3:0] S_LD_MUL   = 4'd4;
	localparam logic [3:0] S_LD_FRAC  = 4'd5;
	localparam logic [3:0] S_LD_FRM   = 4'd6;
	localparam logic [3:0] S_RD_PACK  = 4'd7;
	localparam logic [3:0] S_RD_SCALE = 4'd8;
	localparam logic [3:0] S_RD_GO    = 4'd9;
	localparam logic [3:0] S_RD_DIV   = 4'd10;
	localparam logic [3:0] S_OUT_WAIT = 4'd11;

	// Operand widths of the individual divides
	localparam int Q_W   = 17;
	localparam int MIN_W = 11;
	localparam int X_W   = 25;
	localparam int SCL_W = 12;
	localparam int NUM_W = 25;

	localparam logic [TIME_W-1:0] MAX_TIME_US = 37'd86399999999;
	localparam logic [REM_W-1:0]  US_PER_SEC  = 20'd1000000;
	localparam logic [REM_W-1:0]  DIV_SIXTY   = 20'd60;
	localparam logic [REM_W-1:0]  DIV_FRAC    = 20'd10000;
	localparam logic [REM_W-1:0]  DIV_HUND    = 20'd100;

	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [1:0]        mode_q;
	logic [FPS_W-1:0]  fps;
	logic              accept;
	logic              out_free;
	logic [TIME_W-1:0] t_clamp;

	div_req_t div_req;
	div_rsp_t div_rsp;
	fld_ctl_t fld_ctl;

	logic [REM_W-1:0]  u_q;
	logic [X_W-1:0]    x_q;
	logic [16:0]       secs_q;
	logic [11:0]       hund_q;
	logic [NUM_W-1:0]  num_q;
	logic [TIME_W-1:0] whole_q;
	logic [TIME_W-1:0] time_q;

	logic [4:0]  fld_hours;
	logic [5:0]  fld_minutes;
	logic [5:0]  fld_seconds;
	logic [4:0]  fld_frames;
	logic [6:0]  fld_subframes;
	logic [16:0] fld_secs;
	logic [11:0] fld_hund;

	assign fps      = fps_of(mode_q);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign t_clamp  = (load_time_us > MAX_TIME_US) ? MAX_TIME_US : load_time_us;

	tcq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tcq_fields u_fields (
		.clk       (clk),
		.arst_n    (arst_n),
		.fps       (fps),
		.ctl       (fld_ctl),
		.rsp       (div_rsp),
		.hours     (fld_hours),
		.minutes   (fld_minutes),
		.seconds   (fld_seconds),
		.frames    (fld_frames),
		.subframes (fld_subframes),
		.secs      (fld_secs),
		.hund      (fld_hund)
	);

	// Sequencer: next state, divider requests, field strobes
	always_comb begin
		state_d = state_q;
		div_req = '0;
		fld_ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						div_req.start    = 1'b1;
						div_req.nbits    = CNT_W'(DVD_W);
						div_req.dividend = t_clamp;
						div_req.divisor  = US_PER_SEC;
						state_d          = S_LD_SEC;
					end else begin
						fld_ctl.tick = 1'b1;
						state_d      = S_RD_PACK;
					end
				end
			end
			// whole seconds of the day into minutes and seconds
			S_LD_SEC: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(Q_W);
					div_req.dividend = {div_rsp.quot[Q_W-1:0], {(DVD_W-Q_W){1'b0}}};
					div_req.divisor  = DIV_SIXTY;
					state_d          = S_LD_MIN;
				end
			end
			// minutes of the day into hours and minutes
			S_LD_MIN: begin
				if (div_rsp.done) begin
					fld_ctl.set_sec  = 1'b1;
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(MIN_W);
					div_req.dividend = {div_rsp.quot[MIN_W-1:0], {(DVD_W-MIN_W){1'b0}}};
					div_req.divisor  = DIV_SIXTY;
					state_d          = S_LD_HR;
				end
			end
			S_LD_HR: begin
				if (div_rsp.done) begin
					fld_ctl.set_hm = 1'b1;
					state_d        = S_LD_MUL;
				end
			end
			// hundredths of frames: u * fps / 10000
			S_LD_MUL: begin
				div_req.start    = 1'b1;
				div_req.nbits    = CNT_W'(X_W);
				div_req.dividend = {x_q, {(DVD_W-X_W){1'b0}}};
				div_req.divisor  = DIV_FRAC;
				state_d          = S_LD_FRAC;
			end
			S_LD_FRAC: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(SCL_W);
					div_req.dividend = {div_rsp.quot[SCL_W-1:0], {(DVD_W-SCL_W){1'b0}}};
					div_req.divisor  = DIV_HUND;
					state_d          = S_LD_FRM;
				end
			end
			S_LD_FRM: begin
				if (div_rsp.done) begin
					fld_ctl.set_frm = 1'b1;
					state_d         = S_RD_PACK;
				end
			end
			S_RD_PACK: begin
				state_d = S_RD_SCALE;
			end
			S_RD_SCALE: begin
				state_d = S_RD_GO;
			end
			// fractional microseconds: hundredths * 10000 / fps
			S_RD_GO: begin
				div_req.start    = 1'b1;
				div_req.nbits    = CNT_W'(NUM_W);
				div_req.dividend = {num_q, {(DVD_W-NUM_W){1'b0}}};
				div_req.divisor  = {{(REM_W-FPS_W){1'b0}}, fps};
				state_d          = S_RD_DIV;
			end
			S_RD_DIV: begin
				if (div_rsp.done) begin
					state_d = S_OUT_WAIT;
				end
			end
			S_OUT_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= MODE_24FPS;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (state_q == S_OUT_WAIT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Load and readout datapath
	always_ff @(posedge clk) begin
		if (state_q == S_LD_SEC && div_rsp.done) begin
			u_q <= div_rsp.rem;
		end
		if (state_q == S_LD_HR && div_rsp.done) begin
			x_q <= {{(X_W-REM_W){1'b0}}, u_q} * {{(X_W-FPS_W){1'b0}}, fps};
		end
		if (state_q == S_RD_PACK) begin
			secs_q <= fld_secs;
			hund_q <= fld_hund;
		end
		if (state_q == S_RD_SCALE) begin
			num_q   <= {{(NUM_W-12){1'b0}}, hund_q} * 25'd10000;
			whole_q <= {{(TIME_W-17){1'b0}}, secs_q} * 37'd1000000;
		end
		if (state_q == S_RD_DIV && div_rsp.done) begin
			time_q <= whole_q + div_rsp.quot;
		end
	end

	// Output register, loaded once the previous result has been transferred
	always_ff @(posedge clk) begin
		if (state_q == S_OUT_WAIT && out_free) begin
			hours     <= fld_hours;
			minutes   <= fld_minutes;
			seconds   <= fld_seconds;
			frames    <= fld_frames;
			subframes <= fld_subframes;
			time_us   <= time_q;
		end
	end

`ifndef SYNTH
	// Divider completes only while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_LD_SEC || state_q == S_LD_MIN ||
			state_q == S_LD_HR || state_q == S_LD_FRAC || state_q == S_LD_FRM ||
			state_q == S_RD_DIV))
		else $error("divider done outside a divide state");

	// An accepted item blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after a transfer");

	// A waiting result is never overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_WAIT && out_valid && out_stall) |=> (state_q == S_OUT_WAIT))
		else $error("result register overwritten while stalled");

	// Hours, minutes, seconds and subframes are in range whenever the block is idle
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (fld_hours < 5'd24 && fld_minutes < 6'd60 &&
			fld_seconds < 6'd60 && fld_subframes < 7'd100))
		else $error("timecode field out of range");
`endif

endmodule

// ===== rtl/tcq_div.sv =====
// Restoring divider, one quotient bit per clock, shared by load and readout.
// Depends on tcq_pkg for the request and response structs.
module tcq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tcq_pkg::div_req_t req,
	output tcq_pkg::div_rsp_t rsp
);
	import tcq_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             ge;

	// One restoring step: bring down the next dividend bit, trial subtract
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	// Bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.nbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/tcq_fields.sv =====
// Timecode field registers: quarter-frame advance with carries, load from the
// divider, and packing of the fields for readout. Depends on tcq_pkg.
module tcq_fields (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tcq_pkg::FPS_W-1:0] fps,
	input  tcq_pkg::fld_ctl_t         ctl,
	input  tcq_pkg::div_rsp_t         rsp,
	output logic [4:0]                hours,
	output logic [5:0]                minutes,
	output logic [5:0]                seconds,
	output logic [4:0]                frames,
	output logic [6:0]                subframes,
	output logic [16:0]               secs,
	output logic [11:0]               hund
);
	import tcq_pkg::*;

	logic [4:0] hour_q;
	logic [5:0] min_q;
	logic [5:0] sec_q;
	logic [4:0] frame_q;
	logic [6:0] sub_q;

	logic [4:0] h_t;
	logic [5:0] m_t;
	logic [5:0] s_t;
	logic [4:0] f_t;
	logic [6:0] sf_t;

	// Quarter-frame advance: 25 subframes, carries tested with >=
	always_comb begin
		sf_t = sub_q + 7'd25;
		f_t  = frame_q;
		s_t  = sec_q;
		m_t  = min_q;
		h_t  = hour_q;
		if (sf_t >= 7'd100) begin
			f_t  = f_t + 5'd1;
			sf_t = sf_t - 7'd100;
		end
		if (f_t >= fps) begin
			s_t = s_t + 6'd1;
			f_t = '0;
		end
		if (s_t >= 6'd60) begin
			m_t = m_t + 6'd1;
			s_t = '0;
		end
		if (m_t >= 6'd60) begin
			h_t = h_t + 5'd1;
			m_t = '0;
		end
		if (h_t >= 5'd24) begin
			h_t = '0;
		end
	end

	// Field registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			frame_q <= '0;
			sub_q   <= '0;
		end else if (ctl.tick) begin
			hour_q  <= h_t;
			min_q   <= m_t;
			sec_q   <= s_t;
			frame_q <= f_t;
			sub_q   <= sf_t;
		end else begin
			if (ctl.set_sec) begin
				sec_q <= rsp.rem[5:0];
			end
			if (ctl.set_hm) begin
				hour_q <= rsp.quot[4:0];
				min_q  <= rsp.rem[5:0];
			end
			if (ctl.set_frm) begin
				frame_q <= rsp.quot[4:0];
				sub_q   <= rsp.rem[6:0];
			end
		end
	end

	// Whole seconds of the day and hundredths of frames within the second
	assign secs = {12'd0, hour_q} * 17'd3600 + {11'd0, min_q} * 17'd60 + {11'd0, sec_q};
	assign hund = {7'd0, frame_q} * 12'd100 + {5'd0, sub_q};

	assign hours     = hour_q;
	assign minutes   = min_q;
	assign seconds   = sec_q;
	assign frames    = frame_q;
	assign subframes = sub_q;

endmodule
